// ===== rtl/core/bcio_pkg.sv =====
// shared types and constants for the bridge config / isa i/o block
// no dependencies
`default_nettype none

package bcio_pkg;

    // default sizes of the stores
    localparam int CONFIG_WORDS_DEF = 256;
    localparam int NVRAM_BYTES_DEF  = 4096;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_ID  = 2'd0;
    localparam logic [1:0] REG_INDEX_PORT = 2'd1;
    localparam logic [1:0] REG_DATA_PORT  = 2'd2;

    localparam logic [31:0] DEVICE_ID_RESET  = 32'h0000_0000;
    localparam logic [31:0] INDEX_PORT_RESET = 32'hFEC0_0000;
    localparam logic [31:0] DATA_PORT_RESET  = 32'hFEE0_0000;

    localparam logic [31:0] PORT_MASK = 32'hFFFF_FFC0;

    // config register numbers with special handling
    localparam logic [15:0] CFG_REG_ID      = 16'h0000;
    localparam logic [15:0] CFG_REG_ZERO    = 16'h00A8;
    localparam logic [15:0] CFG_REG_LANE_LO = 16'h00A0;
    localparam logic [15:0] CFG_REG_LANE_HI = 16'h00A3;

    // isa i/o ports
    localparam logic [11:0] IO_NV_HIGH = 12'h074;
    localparam logic [11:0] IO_NV_LOW  = 12'h075;
    localparam logic [11:0] IO_NV_DATA = 12'h076;
    localparam logic [11:0] IO_RTC_IDX = 12'h070;
    localparam logic [11:0] IO_GPIO0   = 12'h700;
    localparam logic [11:0] IO_GPIO1   = 12'h701;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_Q,
        ST_MUL_N,
        ST_REDUCE,
        ST_READ,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_q;
        logic mul_n;
        logic reduce;
        logic mem_rd;
        logic commit;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bridge_config_and_isa_io_ports.sv =====
// Bridge config-space index/data port and ISA I/O port block. An access is
// taken when start is high and busy is low; its single result (read_data,
// zero for writes) appears one cycle with done high and cannot be held off.
// An access is run by a sequencer that reduces the nvram address modulo its
// size with two registered multiplies and then reads the stores before
// writing back; a new access is accepted in the cycle done is high. After
// reset the nvram is cleared one byte a cycle, and busy stays high until the
// clearing pass ends; configuration writes are taken at any time.
// depends on bcio_pkg, bcio_ctrl, bcio_dp, bcio_ram
`default_nettype none

module bridge_config_and_isa_io_ports #(
    parameter int CONFIG_WORDS = bcio_pkg::CONFIG_WORDS_DEF,
    parameter int NVRAM_BYTES  = bcio_pkg::NVRAM_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [31:0] bus_address,
    input  wire logic [31:0] write_data,
    input  wire logic        is_read,
    output logic             done,
    output logic      [31:0] read_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import bcio_pkg::*;

    logic [31:0] device_id_reg;
    logic [31:0] index_port_reg;
    logic [31:0] data_port_reg;

    cmd_t    cmd;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg  <= DEVICE_ID_RESET;
            index_port_reg <= INDEX_PORT_RESET;
            data_port_reg  <= DATA_PORT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_ID:  device_id_reg  <= cfg_data;
                REG_INDEX_PORT: index_port_reg <= cfg_data;
                REG_DATA_PORT:  data_port_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    bcio_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bcio_dp #(
        .CONFIG_WORDS (CONFIG_WORDS),
        .NVRAM_BYTES  (NVRAM_BYTES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .device_id          (device_id_reg),
        .index_port_address (index_port_reg),
        .data_port_address  (data_port_reg),
        .func               (func),
        .bus_address        (bus_address),
        .write_data         (write_data),
        .is_read            (is_read),
        .read_data          (read_data)
    );

    // at most one sequencer step at a time
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one datapath command active");

    // an accepted item keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // the result strobe comes as the block returns idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> (!busy && $past(busy)))
        else $error("done without a finished item");

    // no clearing step once items are being served
    assert property (@(posedge clk) disable iff (!rst_n) cmd.capture |=> !cmd.clear_step)
        else $error("nvram clear during an item");

endmodule

`default_nettype wire

// ===== rtl/core/bcio_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module bcio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bcio_ctrl.sv =====
// sequencing state machine for one bus access and the nvram clearing pass
// depends on bcio_pkg
`default_nettype none

module bcio_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bcio_pkg::status_t status,
    output bcio_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);
    import bcio_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.commit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL_Q;
                end
            end
            ST_MUL_Q:
            begin
                cmd.mul_q  = 1'b1;
                state_next = ST_MUL_N;
            end
            ST_MUL_N:
            begin
                cmd.mul_n  = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcio_dp.sv =====
// datapath: item registers, nvram address reduction, config and nvram stores, port latches
// depends on bcio_pkg and bcio_ram
`default_nettype none

module bcio_dp #(
    parameter int CONFIG_WORDS = bcio_pkg::CONFIG_WORDS_DEF,
    parameter int NVRAM_BYTES  = bcio_pkg::NVRAM_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bcio_pkg::cmd_t cmd,
    output bcio_pkg::status_t   status,
    input  wire logic [31:0]    device_id,
    input  wire logic [31:0]    index_port_address,
    input  wire logic [31:0]    data_port_address,
    input  wire logic           func,
    input  wire logic [31:0]    bus_address,
    input  wire logic [31:0]    write_data,
    input  wire logic           is_read,
    output logic      [31:0]    read_data
);
    import bcio_pkg::*;

    localparam int CW  = $clog2(CONFIG_WORDS);
    localparam int NVW = $clog2(NVRAM_BYTES);
    localparam logic [8:0]  CFG_LIMIT = 9'(CONFIG_WORDS);
    localparam logic [16:0] NV_N      = 17'(NVRAM_BYTES);
    localparam logic [16:0] NV_LAST   = 17'(NVRAM_BYTES - 1);
    // floor(2^32 / n): quotient estimate is low by at most one
    localparam logic [31:0] NV_RECIP  = 32'((64'd1 << 32) / NVRAM_BYTES);

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // item registers
    logic        func_reg;
    logic [31:0] addr_reg;
    logic [31:0] wdata_reg;
    logic        rd_reg;

    // latched port state
    logic [31:0] config_index_reg;
    logic [7:0]  nv_high_reg;
    logic [7:0]  nv_low_reg;
    logic [7:0]  rtc_index_reg;
    logic [7:0]  gpio0_reg;
    logic [7:0]  gpio1_reg;
    logic [CONFIG_WORDS-1:0] cfg_valid_reg;

    // address reduction pipeline
    logic [47:0]    prod1_reg;
    logic [16:0]    prod2_reg;
    logic [NVW-1:0] nv_addr_reg;
    logic [NVW-1:0] clr_cnt_reg;
    logic           cfg_valid_q_reg;
    logic [31:0]    read_data_reg;

    logic [15:0]    nv_lin;
    logic [16:0]    nv_rem;
    logic [16:0]    nv_red;

    logic [31:0]    cfg_rdata;
    logic [7:0]     nv_rdata;
    logic           cfg_we;
    logic [31:0]    cfg_wdata;
    logic           nv_we;
    logic [NVW-1:0] nv_waddr;
    logic [7:0]     nv_wdata;

    // decode
    logic [31:0] port;
    logic        hit_index;
    logic        hit_data;
    logic [15:0] cfg_r;
    logic [7:0]  cfg_e;
    logic [CW-1:0] entry;
    logic        in_range;
    logic [11:0] io_port;
    logic [7:0]  vb;
    logic [7:0]  gpio_val;
    logic [31:0] wd_swap;
    logic [31:0] old_word;
    logic [31:0] lane_mask;
    logic [31:0] cfg_value;
    logic [31:0] result;

    assign nv_lin = {nv_high_reg, nv_low_reg};
    assign nv_rem = {1'b0, nv_lin} - prod2_reg;
    assign nv_red = (nv_rem >= NV_N) ? (nv_rem - NV_N) : nv_rem;

    assign port      = addr_reg & PORT_MASK;
    assign hit_index = (port == (index_port_address & PORT_MASK));
    assign hit_data  = !hit_index && (port == (data_port_address & PORT_MASK));
    assign cfg_r     = config_index_reg[15:0];
    assign cfg_e     = config_index_reg[7:0];
    assign entry     = cfg_e[CW-1:0];
    assign in_range  = ({1'b0, cfg_e} < CFG_LIMIT);
    assign io_port   = addr_reg[11:0];
    assign vb        = wdata_reg[7:0];
    assign gpio_val  = {vb[7], vb[7], vb[5:0]};
    assign wd_swap   = swap32(wdata_reg);
    assign old_word  = cfg_valid_q_reg ? cfg_rdata : 32'd0;
    assign lane_mask = 32'h0000_00FF << {addr_reg[1:0], 3'b000};

    always_comb
    begin
        if (cfg_r == CFG_REG_ID)
        begin
            cfg_value = device_id;
        end
        else if (cfg_r == CFG_REG_ZERO)
        begin
            cfg_value = 32'd0;
        end
        else if (in_range)
        begin
            cfg_value = old_word;
        end
        else
        begin
            cfg_value = 32'hFFFF_FFFF;
        end
    end

    always_comb
    begin
        result = 32'd0;
        if (!func_reg)
        begin
            if (hit_data)
            begin
                result = swap32(cfg_value);
            end
        end
        else
        begin
            case (io_port)
                IO_NV_HIGH: result = {4{nv_high_reg}};
                IO_NV_LOW:  result = {4{nv_low_reg}};
                IO_NV_DATA: result = {4{nv_rdata}};
                IO_RTC_IDX: result = {4{rtc_index_reg}};
                IO_GPIO0:   result = {4{gpio0_reg}};
                IO_GPIO1:   result = {4{gpio1_reg}};
                default:    result = 32'd0;
            endcase
        end
    end

    // config store write, byte lane registers merge into the old word
    assign cfg_we = cmd.commit && !func_reg && !rd_reg && hit_data
                    && (cfg_r != CFG_REG_ID) && in_range;
    assign cfg_wdata = ((cfg_r >= CFG_REG_LANE_LO) && (cfg_r <= CFG_REG_LANE_HI))
                       ? ((old_word & ~lane_mask) | (wd_swap & lane_mask))
                       : wd_swap;

    // nvram write port is shared with the clearing pass
    assign nv_we    = cmd.clear_step
                      || (cmd.commit && func_reg && !rd_reg && (io_port == IO_NV_DATA));
    assign nv_waddr = cmd.clear_step ? clr_cnt_reg : nv_addr_reg;
    assign nv_wdata = cmd.clear_step ? 8'd0 : vb;

    assign status.clear_last = (clr_cnt_reg == NV_LAST[NVW-1:0]);

    bcio_ram #(
        .WIDTH (32),
        .DEPTH (CONFIG_WORDS)
    ) u_cfg_ram (
        .clk   (clk),
        .we    (cfg_we),
        .waddr (entry),
        .wdata (cfg_wdata),
        .raddr (entry),
        .rdata (cfg_rdata)
    );

    bcio_ram #(
        .WIDTH (8),
        .DEPTH (NVRAM_BYTES)
    ) u_nv_ram (
        .clk   (clk),
        .we    (nv_we),
        .waddr (nv_waddr),
        .wdata (nv_wdata),
        .raddr (nv_addr_reg),
        .rdata (nv_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            addr_reg  <= bus_address;
            wdata_reg <= write_data;
            rd_reg    <= is_read;
        end
        if (cmd.mul_q)
        begin
            prod1_reg <= {32'd0, nv_lin} * {16'd0, NV_RECIP};
        end
        if (cmd.mul_n)
        begin
            prod2_reg <= {1'b0, prod1_reg[47:32]} * NV_N;
        end
        if (cmd.reduce)
        begin
            nv_addr_reg <= nv_red[NVW-1:0];
        end
        if (cmd.mem_rd)
        begin
            cfg_valid_q_reg <= cfg_valid_reg[entry];
        end
        if (cmd.commit)
        begin
            read_data_reg <= rd_reg ? result : 32'd0;
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            config_index_reg <= '0;
            nv_high_reg      <= '0;
            nv_low_reg       <= '0;
            rtc_index_reg    <= '0;
            gpio0_reg        <= '0;
            gpio1_reg        <= '0;
            cfg_valid_reg    <= '0;
            clr_cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                cfg_valid_reg[entry] <= 1'b1;
            end
            if (cmd.commit && !rd_reg)
            begin
                if (!func_reg)
                begin
                    if (hit_index)
                    begin
                        config_index_reg <= wd_swap;
                    end
                end
                else
                begin
                    case (io_port)
                        IO_NV_HIGH: nv_high_reg   <= vb;
                        IO_NV_LOW:  nv_low_reg    <= vb;
                        IO_RTC_IDX: rtc_index_reg <= vb;
                        IO_GPIO0:   gpio0_reg     <= gpio_val;
                        IO_GPIO1:   gpio1_reg     <= gpio_val;
                        default:    ;
                    endcase
                end
            end
        end
    end

    assign read_data = read_data_reg;

endmodule

`default_nettype wire
